// ===== sv/tad_pkg.sv =====
// ---------------------------------------------------------------------------
// tad_pkg
// Shared constants, widths and payload types of the tile average downscaler.
// ---------------------------------------------------------------------------
`default_nettype none

package tad_pkg;

  // grid and image limits
  localparam int GRID_COLS     = 64;
  localparam int GRID_ROWS     = 32;
  localparam int MAX_IMAGE_DIM = 4096;

  // fixed field widths
  localparam int PIX_W      = 8;
  localparam int DIM_W      = 13;
  localparam int TILE_ROW_W = 5;
  localparam int TILE_COL_W = 6;

  // configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
  localparam logic [DIM_W-1:0]     IMAGE_WIDTH_RST  = 13'd64;
  localparam logic [DIM_W-1:0]     IMAGE_HEIGHT_RST = 13'd32;

  // derived widths
  localparam int POS_W        = $clog2(MAX_IMAGE_DIM);
  localparam int TW_W         = $clog2(MAX_IMAGE_DIM / GRID_COLS + 1);
  localparam int TH_W         = $clog2(MAX_IMAGE_DIM / GRID_ROWS + 1);
  localparam int COL_IDX_W    = $clog2(GRID_COLS);
  localparam int COL_CNT_W    = $clog2(GRID_COLS) + 1;
  localparam int ROW_CNT_W    = $clog2(GRID_ROWS) + 1;
  localparam int MAX_TILE_PIX = (MAX_IMAGE_DIM / GRID_COLS) * (MAX_IMAGE_DIM / GRID_ROWS);
  localparam int CNT_W        = $clog2(MAX_TILE_PIX + 1);
  localparam int SUM_W        = PIX_W + $clog2(MAX_TILE_PIX);

  // mean = (sum * recip) >> RECIP_SHIFT, plus one correction step
  localparam int RECIP_SHIFT = SUM_W;
  localparam int RECIP_W     = SUM_W + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int QD_W        = PIX_W + CNT_W;

  localparam int OUT_FIFO_DEPTH = 8;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sums_t;

  localparam int SUMS_W = $bits(sums_t);

  typedef struct packed {
    logic [TILE_ROW_W-1:0] row;
    logic [TILE_COL_W-1:0] col;
    logic [PIX_W-1:0]      avg_red;
    logic [PIX_W-1:0]      avg_green;
    logic [PIX_W-1:0]      avg_blue;
    logic                  last;
  } tile_t;

endpackage

`default_nettype wire

// ===== sv/tad_if.sv =====
// ---------------------------------------------------------------------------
// tad_if
// Valid/ready channels of the tile average downscaler: pixel in, tile out.
// ---------------------------------------------------------------------------
`default_nettype none

interface tad_pixel_if;
  logic                      valid;
  logic                      ready;
  logic [tad_pkg::PIX_W-1:0] pixel_red;
  logic [tad_pkg::PIX_W-1:0] pixel_green;
  logic [tad_pkg::PIX_W-1:0] pixel_blue;
  logic                      frame_start;

  modport source (output valid, pixel_red, pixel_green, pixel_blue, frame_start,
                  input ready);
  modport sink   (input valid, pixel_red, pixel_green, pixel_blue, frame_start,
                  output ready);
endinterface

interface tad_tile_if;
  logic                           valid;
  logic                           ready;
  logic [tad_pkg::TILE_ROW_W-1:0] tile_row;
  logic [tad_pkg::TILE_COL_W-1:0] tile_col;
  logic [tad_pkg::PIX_W-1:0]      avg_red;
  logic [tad_pkg::PIX_W-1:0]      avg_green;
  logic [tad_pkg::PIX_W-1:0]      avg_blue;
  logic                           last_tile;

  modport source (output valid, tile_row, tile_col, avg_red, avg_green, avg_blue,
                  last_tile, input ready);
  modport sink   (input valid, tile_row, tile_col, avg_red, avg_green, avg_blue,
                  last_tile, output ready);
endinterface

`default_nettype wire

// ===== sv/tile_average_downscaler_unit.sv =====
// ---------------------------------------------------------------------------
// tile_average_downscaler_unit
// Tile grid box-average downscaler for raster RGB pixels.
// ---------------------------------------------------------------------------
// Pixels enter on pix (valid/ready), one beat per pixel in raster order;
// frame_start on a beat restarts the raster position at that pixel. A tile
// result (grid row/col, three truncated means, last_tile) leaves on tile,
// zero or one per pixel, in pixel order.
// Throughput: one pixel per clock sustained while pix.ready is high. The
// per-column sums live in a 64-entry RAM; each pixel does a read in its accept
// cycle and the add and write-back in the next, with a bypass for back-to-back
// pixels of one column. A tile's last pixel passes the read-modify-write and
// emit stages and mean stages a and b before its result enters the queue.
// Reset, and every config write, starts a setup pass (reciprocal of the tile
// pixel count by a 22-step serial divider, tile position from the raster
// position) during which pix.ready is low. The results wait in an 8-entry
// queue; a stalled receiver fills it, and outside setup pix.ready drops only
// when the queue plus the results in flight reach its depth.
// ---------------------------------------------------------------------------
`default_nettype none

module tile_average_downscaler_unit #(
  parameter int OUT_FIFO_DEPTH = tad_pkg::OUT_FIFO_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  tad_pixel_if.sink                          pix,
  tad_tile_if.source                         tile,
  input  wire logic                          cfg_write_en,
  input  wire logic [tad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tad_pkg::DIM_W-1:0]     cfg_data
);

  localparam int DIM_W     = tad_pkg::DIM_W;
  localparam int POS_W     = tad_pkg::POS_W;
  localparam int TW_W      = tad_pkg::TW_W;
  localparam int TH_W      = tad_pkg::TH_W;
  localparam int CNT_W     = tad_pkg::CNT_W;
  localparam int COL_CNT_W = tad_pkg::COL_CNT_W;
  localparam int ROW_CNT_W = tad_pkg::ROW_CNT_W;
  localparam int COL_IDX_W = tad_pkg::COL_IDX_W;
  localparam int SUM_W     = tad_pkg::SUM_W;
  localparam int RECIP_W   = tad_pkg::RECIP_W;
  localparam int FCNT_W    = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int OCC_W     = $clog2(OUT_FIFO_DEPTH + 6);

  localparam logic [1:0] ST_LOAD  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_RUN   = 2'd3;

  localparam logic [DIM_W-1:0]     W_MIN   = DIM_W'(tad_pkg::GRID_COLS);
  localparam logic [DIM_W-1:0]     H_MIN   = DIM_W'(tad_pkg::GRID_ROWS);
  localparam logic [DIM_W-1:0]     DIM_MAX = DIM_W'(tad_pkg::MAX_IMAGE_DIM);
  localparam logic [COL_CNT_W-1:0] COL_SAT = '1;
  localparam logic [ROW_CNT_W-1:0] ROW_SAT = '1;

  // configuration and derived tile geometry
  logic [DIM_W-1:0]   image_width;
  logic [DIM_W-1:0]   image_height;
  logic [DIM_W-1:0]   w_clamp;
  logic [DIM_W-1:0]   h_clamp;
  logic [TW_W-1:0]    tw_next;
  logic [TH_W-1:0]    th_next;
  logic [DIM_W-1:0]   wc_reg;
  logic [DIM_W-1:0]   hc_reg;
  logic [TW_W-1:0]    tw_reg;
  logic [TH_W-1:0]    th_reg;
  logic [CNT_W-1:0]   cnt_reg;
  logic [RECIP_W-1:0] recip_reg;
  logic [1:0]         state;

  // setup dividers
  logic               div_start;
  logic               x_busy;
  logic               y_busy;
  logic               m_busy;
  logic [POS_W-1:0]   x_quo;
  logic [TW_W-1:0]    x_rem;
  logic [POS_W-1:0]   y_quo;
  logic [TH_W-1:0]    y_rem;
  logic [RECIP_W-1:0] m_quo;

  // raster position
  logic [POS_W-1:0]     pixel_x;
  logic [POS_W-1:0]     pixel_y;
  logic [TW_W-1:0]      x_within_tile;
  logic [TH_W-1:0]      y_within_tile;
  logic [COL_CNT_W-1:0] current_tile_col;
  logic [ROW_CNT_W-1:0] current_tile_row;

  logic [POS_W-1:0]     eff_x;
  logic [POS_W-1:0]     eff_y;
  logic [TW_W-1:0]      eff_xt;
  logic [TH_W-1:0]      eff_yt;
  logic [COL_CNT_W-1:0] eff_col;
  logic [ROW_CNT_W-1:0] eff_row;

  logic [POS_W-1:0]     pixel_x_next;
  logic [POS_W-1:0]     pixel_y_next;
  logic [TW_W-1:0]      x_within_tile_next;
  logic [TH_W-1:0]      y_within_tile_next;
  logic [COL_CNT_W-1:0] current_tile_col_next;
  logic [ROW_CNT_W-1:0] current_tile_row_next;

  logic accept;
  logic covered;
  logic tile_first;
  logic tile_last;

  // read-modify-write stage
  logic                           s1_valid;
  logic                           s1_first;
  logic                           s1_last;
  logic [COL_IDX_W-1:0]           s1_col;
  logic [tad_pkg::TILE_ROW_W-1:0] s1_row;
  tad_pkg::sums_t                 s1_pix;
  tad_pkg::sums_t                 ram_rd;
  tad_pkg::sums_t                 base;
  tad_pkg::sums_t                 sums_new;
  logic                           wb_valid;
  logic [COL_IDX_W-1:0]           wb_col;
  tad_pkg::sums_t                 wb_data;

  // emit stage
  logic                           s2_valid;
  tad_pkg::sums_t                 s2_sums;
  logic [tad_pkg::TILE_ROW_W-1:0] s2_row;
  logic [tad_pkg::TILE_COL_W-1:0] s2_col;
  logic                           s2_last;

  logic           mean_valid;
  tad_pkg::tile_t mean_tile;
  logic [1:0]     mean_inflight;
  tad_pkg::tile_t fifo_out;
  logic [FCNT_W-1:0] fifo_count;
  logic [OCC_W-1:0]  occupancy;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= tad_pkg::IMAGE_WIDTH_RST;
      image_height <= tad_pkg::IMAGE_HEIGHT_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        tad_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        tad_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_clamp = (image_width < W_MIN) ? W_MIN :
                   (image_width > DIM_MAX) ? DIM_MAX : image_width;
  assign h_clamp = (image_height < H_MIN) ? H_MIN :
                   (image_height > DIM_MAX) ? DIM_MAX : image_height;
  assign tw_next = TW_W'(w_clamp / tad_pkg::GRID_COLS);
  assign th_next = TH_W'(h_clamp / tad_pkg::GRID_ROWS);

  // ---------------- setup sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst || cfg_write_en) begin
      state <= ST_LOAD;
    end else begin
      unique case (state)
        ST_LOAD:  state <= ST_START;
        ST_START: state <= ST_WAIT;
        ST_WAIT:  state <= (x_busy || y_busy || m_busy) ? ST_WAIT : ST_RUN;
        ST_RUN:   state <= ST_RUN;
        default:  state <= ST_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      wc_reg  <= w_clamp;
      hc_reg  <= h_clamp;
      tw_reg  <= tw_next;
      th_reg  <= th_next;
      cnt_reg <= CNT_W'(tw_next * th_next);
    end
    if (state == ST_WAIT && !(x_busy || y_busy || m_busy)) begin
      recip_reg <= m_quo;
    end
  end

  assign div_start = state == ST_START;

  tad_divider #(.NUM_W(POS_W), .DEN_W(TW_W)) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numer     (pixel_x),
    .denom     (tw_reg),
    .busy      (x_busy),
    .quotient  (x_quo),
    .remainder (x_rem)
  );

  tad_divider #(.NUM_W(POS_W), .DEN_W(TH_W)) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numer     (pixel_y),
    .denom     (th_reg),
    .busy      (y_busy),
    .quotient  (y_quo),
    .remainder (y_rem)
  );

  // recip = floor(2^SUM_W / tile pixel count)
  tad_divider #(.NUM_W(RECIP_W), .DEN_W(CNT_W)) u_div_recip (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numer     ({1'b1, {SUM_W{1'b0}}}),
    .denom     (cnt_reg),
    .busy      (m_busy),
    .quotient  (m_quo),
    .remainder ()
  );

  // ---------------- raster position ----------------
  assign occupancy = OCC_W'(fifo_count) + OCC_W'(s1_valid && s1_last) + OCC_W'(s2_valid)
                   + OCC_W'(mean_inflight);
  assign pix.ready = (state == ST_RUN) && (occupancy < OCC_W'(OUT_FIFO_DEPTH));
  assign accept    = pix.valid && pix.ready;

  assign eff_x   = pix.frame_start ? '0 : pixel_x;
  assign eff_y   = pix.frame_start ? '0 : pixel_y;
  assign eff_xt  = pix.frame_start ? '0 : x_within_tile;
  assign eff_yt  = pix.frame_start ? '0 : y_within_tile;
  assign eff_col = pix.frame_start ? '0 : current_tile_col;
  assign eff_row = pix.frame_start ? '0 : current_tile_row;

  assign covered    = (eff_col < COL_CNT_W'(tad_pkg::GRID_COLS)) &&
                      (eff_row < ROW_CNT_W'(tad_pkg::GRID_ROWS));
  assign tile_first = (eff_xt == '0) && (eff_yt == '0);
  assign tile_last  = (eff_xt == tw_reg - 1'b1) && (eff_yt == th_reg - 1'b1);

  // tile column/row saturate past the grid; line wrap clears column, frame wrap row
  always_comb begin
    pixel_x_next          = eff_x + 1'b1;
    pixel_y_next          = eff_y;
    x_within_tile_next    = eff_xt + 1'b1;
    y_within_tile_next    = eff_yt;
    current_tile_col_next = eff_col;
    current_tile_row_next = eff_row;
    if (eff_xt == tw_reg - 1'b1) begin
      x_within_tile_next    = '0;
      current_tile_col_next = (eff_col == COL_SAT) ? COL_SAT : eff_col + 1'b1;
    end
    if ((DIM_W'(eff_x) + 1'b1) >= wc_reg) begin
      pixel_x_next          = '0;
      x_within_tile_next    = '0;
      current_tile_col_next = '0;
      if ((DIM_W'(eff_y) + 1'b1) >= hc_reg) begin
        pixel_y_next          = '0;
        y_within_tile_next    = '0;
        current_tile_row_next = '0;
      end else begin
        pixel_y_next = eff_y + 1'b1;
        if (eff_yt == th_reg - 1'b1) begin
          y_within_tile_next    = '0;
          current_tile_row_next = (eff_row == ROW_SAT) ? ROW_SAT : eff_row + 1'b1;
        end else begin
          y_within_tile_next = eff_yt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_x          <= '0;
      pixel_y          <= '0;
      x_within_tile    <= '0;
      y_within_tile    <= '0;
      current_tile_col <= '0;
      current_tile_row <= '0;
    end else if (state == ST_WAIT && !(x_busy || y_busy || m_busy)) begin
      // tile position rebuilt from the raster position after a size change
      x_within_tile    <= x_rem;
      y_within_tile    <= y_rem;
      current_tile_col <= (x_quo > POS_W'(COL_SAT)) ? COL_SAT : COL_CNT_W'(x_quo);
      current_tile_row <= (y_quo > POS_W'(ROW_SAT)) ? ROW_SAT : ROW_CNT_W'(y_quo);
    end else if (accept) begin
      pixel_x          <= pixel_x_next;
      pixel_y          <= pixel_y_next;
      x_within_tile    <= x_within_tile_next;
      y_within_tile    <= y_within_tile_next;
      current_tile_col <= current_tile_col_next;
      current_tile_row <= current_tile_row_next;
    end
  end

  // ---------------- column sums: read, add, write back ----------------
  tad_ram #(.WIDTH(tad_pkg::SUMS_W), .DEPTH(tad_pkg::GRID_COLS)) u_sums (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (sums_new),
    .rd_addr (eff_col[COL_IDX_W-1:0]),
    .rd_data (ram_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      wb_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= accept && covered;
      wb_valid <= s1_valid;
      s2_valid <= s1_valid && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_first     <= tile_first;
    s1_last      <= tile_last;
    s1_col       <= eff_col[COL_IDX_W-1:0];
    s1_row       <= eff_row[tad_pkg::TILE_ROW_W-1:0];
    s1_pix.red   <= SUM_W'(pix.pixel_red);
    s1_pix.green <= SUM_W'(pix.pixel_green);
    s1_pix.blue  <= SUM_W'(pix.pixel_blue);
    wb_col       <= s1_col;
    wb_data      <= sums_new;
    s2_sums      <= sums_new;
    s2_row       <= s1_row;
    s2_col       <= tad_pkg::TILE_COL_W'(s1_col);
    s2_last      <= (s1_row == tad_pkg::TILE_ROW_W'(tad_pkg::GRID_ROWS - 1)) &&
                    (s1_col == COL_IDX_W'(tad_pkg::GRID_COLS - 1));
  end

  // last cycle's write to the same column is not yet in the read data
  assign base = (wb_valid && wb_col == s1_col) ? wb_data : ram_rd;

  always_comb begin
    if (s1_first) begin
      sums_new = s1_pix;
    end else begin
      sums_new.red   = base.red   + s1_pix.red;
      sums_new.green = base.green + s1_pix.green;
      sums_new.blue  = base.blue  + s1_pix.blue;
    end
  end

  // ---------------- means and result queue ----------------
  tad_mean u_mean (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_sums   (s2_sums),
    .in_row    (s2_row),
    .in_col    (s2_col),
    .in_last   (s2_last),
    .recip     (recip_reg),
    .count     (cnt_reg),
    .out_valid (mean_valid),
    .out_tile  (mean_tile),
    .inflight  (mean_inflight)
  );

  tad_fifo #(.DEPTH(OUT_FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (mean_valid),
    .push_data (mean_tile),
    .out_valid (tile.valid),
    .out_ready (tile.ready),
    .out_data  (fifo_out),
    .count     (fifo_count)
  );

  assign tile.tile_row  = fifo_out.row;
  assign tile.tile_col  = fifo_out.col;
  assign tile.avg_red   = fifo_out.avg_red;
  assign tile.avg_green = fifo_out.avg_green;
  assign tile.avg_blue  = fifo_out.avg_blue;
  assign tile.last_tile = fifo_out.last;

endmodule

`default_nettype wire

// ===== sv/tad_ram.sv =====
// ---------------------------------------------------------------------------
// tad_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module tad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tad_divider.sv =====
// ---------------------------------------------------------------------------
// tad_divider
// Restoring divider, one quotient bit per cycle; used at setup time only.
// ---------------------------------------------------------------------------
`default_nettype none

module tad_divider #(
  parameter int NUM_W = 12,
  parameter int DEN_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] numer,
  input  wire logic [DEN_W-1:0] denom,
  output logic                  busy,
  output logic      [NUM_W-1:0] quotient,
  output logic      [DEN_W-1:0] remainder
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [STEP_W-1:0] steps;
  logic [NUM_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W:0]    trial;
  logic [DEN_W:0]    diff;
  logic              ge;

  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = trial >= {1'b0, denom};
  assign diff  = trial - {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= STEP_W'(NUM_W);
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
    end
  end

  // dividend bits shift out of the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= numer;
      rem <= '0;
    end else if (steps != '0) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign busy      = steps != '0;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

// ===== sv/tad_mean.sv =====
// ---------------------------------------------------------------------------
// tad_mean
// Three-channel tile mean: multiply by the tile reciprocal, then one
// compare-and-correct step to get the exact truncated quotient.
// ---------------------------------------------------------------------------
`default_nettype none

module tad_mean (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire tad_pkg::sums_t                 in_sums,
  input  wire logic [tad_pkg::TILE_ROW_W-1:0] in_row,
  input  wire logic [tad_pkg::TILE_COL_W-1:0] in_col,
  input  wire logic                           in_last,
  input  wire logic [tad_pkg::RECIP_W-1:0]    recip,
  input  wire logic [tad_pkg::CNT_W-1:0]      count,
  output logic                                out_valid,
  output tad_pkg::tile_t                      out_tile,
  output logic [1:0]                          inflight
);

  localparam int SUM_W  = tad_pkg::SUM_W;
  localparam int PROD_W = tad_pkg::PROD_W;
  localparam int QD_W   = tad_pkg::QD_W;
  localparam int PIX_W  = tad_pkg::PIX_W;

  logic [SUM_W-1:0] ch_sum [3];

  // stage a: product with the reciprocal
  logic                           a_valid;
  logic [SUM_W-1:0]               a_sum  [3];
  logic [PROD_W-1:0]              a_prod [3];
  logic [tad_pkg::TILE_ROW_W-1:0] a_row;
  logic [tad_pkg::TILE_COL_W-1:0] a_col;
  logic                           a_last;

  // stage b: estimate (exact or one low) and estimate * count
  logic                           b_valid;
  logic [SUM_W-1:0]               b_sum [3];
  logic [PIX_W-1:0]               b_q0  [3];
  logic [QD_W-1:0]                b_qd  [3];
  logic [tad_pkg::TILE_ROW_W-1:0] b_row;
  logic [tad_pkg::TILE_COL_W-1:0] b_col;
  logic                           b_last;

  logic [PIX_W-1:0] mean [3];

  assign ch_sum[0] = in_sums.red;
  assign ch_sum[1] = in_sums.green;
  assign ch_sum[2] = in_sums.blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_row  <= in_row;
    a_col  <= in_col;
    a_last <= in_last;
    b_row  <= a_row;
    b_col  <= a_col;
    b_last <= a_last;
  end

  for (genvar i = 0; i < 3; i++) begin : g_ch
    logic [SUM_W-1:0] resid;

    always_ff @(posedge clk) begin
      a_sum[i]  <= ch_sum[i];
      a_prod[i] <= PROD_W'(ch_sum[i]) * PROD_W'(recip);
      b_sum[i]  <= a_sum[i];
      b_q0[i]   <= a_prod[i][tad_pkg::RECIP_SHIFT +: PIX_W];
      b_qd[i]   <= QD_W'(a_prod[i][tad_pkg::RECIP_SHIFT +: PIX_W]) * QD_W'(count);
    end

    // estimate never exceeds the true quotient, so the residue is non-negative
    assign resid   = b_sum[i] - SUM_W'(b_qd[i]);
    assign mean[i] = (resid >= SUM_W'(count)) ? b_q0[i] + 1'b1 : b_q0[i];
  end

  assign out_valid          = b_valid;
  assign out_tile.row       = b_row;
  assign out_tile.col       = b_col;
  assign out_tile.avg_red   = mean[0];
  assign out_tile.avg_green = mean[1];
  assign out_tile.avg_blue  = mean[2];
  assign out_tile.last      = b_last;

  assign inflight = {1'b0, a_valid} + {1'b0, b_valid};

endmodule

`default_nettype wire

// ===== sv/tad_fifo.sv =====
// ---------------------------------------------------------------------------
// tad_fifo
// Small result queue between the mean pipeline and the tile channel.
// ---------------------------------------------------------------------------
`default_nettype none

module tad_fifo #(
  parameter int DEPTH = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire tad_pkg::tile_t             push_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output tad_pkg::tile_t                  out_data,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int PTR_W = $clog2(DEPTH);

  tad_pkg::tile_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != '0;
  assign out_data  = mem[rd_ptr];

  // the producer holds off on a full queue, so push never overflows
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/tad_checker.sv =====
// ---------------------------------------------------------------------------
// tad_checker
// Port-level checks of the tile average downscaler, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module tad_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           pix_ready,
  input wire logic                           cfg_write_en,
  input wire logic                           tile_valid,
  input wire logic                           tile_ready,
  input wire logic [tad_pkg::TILE_ROW_W-1:0] tile_row,
  input wire logic [tad_pkg::TILE_COL_W-1:0] tile_col,
  input wire logic [tad_pkg::PIX_W-1:0]      avg_red,
  input wire logic [tad_pkg::PIX_W-1:0]      avg_green,
  input wire logic [tad_pkg::PIX_W-1:0]      avg_blue,
  input wire logic                           last_tile
);

  // reset empties the result queue and starts setup
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !tile_valid && !pix_ready)
    else $error("output or input open right after reset");

  // a config write always triggers a setup pass before the next pixel
  a_cfg_setup: assert property (@(posedge clk) disable iff (rst)
    cfg_write_en |=> !pix_ready)
    else $error("pixel input open right after a config write");

  // a stalled result beat holds
  a_tile_hold: assert property (@(posedge clk) disable iff (rst)
    tile_valid && !tile_ready |=> tile_valid && $stable(tile_row) && $stable(tile_col)
      && $stable(avg_red) && $stable(avg_green) && $stable(avg_blue) && $stable(last_tile))
    else $error("stalled tile beat changed");

  // end of frame only on the bottom-right tile
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    tile_valid && last_tile |->
      tile_row == tad_pkg::TILE_ROW_W'(tad_pkg::GRID_ROWS - 1) &&
      tile_col == tad_pkg::TILE_COL_W'(tad_pkg::GRID_COLS - 1))
    else $error("last_tile on a tile other than the bottom-right one");

endmodule

bind tile_average_downscaler_unit tad_checker u_tad_checker (
  .clk          (clk),
  .rst          (rst),
  .pix_ready    (pix.ready),
  .cfg_write_en (cfg_write_en),
  .tile_valid   (tile.valid),
  .tile_ready   (tile.ready),
  .tile_row     (tile.tile_row),
  .tile_col     (tile.tile_col),
  .avg_red      (tile.avg_red),
  .avg_green    (tile.avg_green),
  .avg_blue     (tile.avg_blue),
  .last_tile    (tile.last_tile)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for tile_average_downscaler_unit.
// ---------------------------------------------------------------------------
// Raster RGB beats go in through a queue-fed driver. Every accepted beat runs
// through a behavioral tile-mean model that produces the expected tiles. Each
// accepted tile is checked field by field against the oldest expected one.
// The image size is changed only when the unit is drained. This covers the
// clamped extremes, a resize part way through a frame, and random geometries.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import tad_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             start;
  } pix_beat_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;

  tad_pixel_if pix_ch ();
  tad_tile_if  tile_ch ();

  tile_average_downscaler_unit dut (
    .clk          (clk),
    .rst          (rst),
    .pix          (pix_ch),
    .tile         (tile_ch),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  pix_beat_t   pixel_backlog[$];
  tile_t       pending_tiles[$];
  pix_beat_t   next_beat;
  bit          steady;
  int unsigned mismatch_count;

  // model state
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic [SUM_W-1:0] red_sums   [GRID_COLS];
  logic [SUM_W-1:0] green_sums [GRID_COLS];
  logic [SUM_W-1:0] blue_sums  [GRID_COLS];
  int unsigned      rast_x;
  int unsigned      rast_y;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v, input int unsigned lo);
    if (v < lo) return lo;
    if (v > MAX_IMAGE_DIM) return MAX_IMAGE_DIM;
    return v;
  endfunction

  task automatic accumulate_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                  input logic [PIX_W-1:0] b, input logic start);
    int unsigned w, h, tw, th, col, row, xin, yin, area;
    tile_t t;
    w  = clamp_dim(width_reg, GRID_COLS);
    h  = clamp_dim(height_reg, GRID_ROWS);
    tw = w / GRID_COLS;
    th = h / GRID_ROWS;
    if (start) begin
      rast_x = 0;
      rast_y = 0;
    end
    col = rast_x / tw;
    row = rast_y / th;
    xin = rast_x % tw;
    yin = rast_y % th;
    // pixels right of or below the tiled region fall through
    if (col < GRID_COLS && row < GRID_ROWS) begin
      if (xin == 0 && yin == 0) begin
        red_sums[col]   = r;
        green_sums[col] = g;
        blue_sums[col]  = b;
      end else begin
        red_sums[col]   = red_sums[col] + r;
        green_sums[col] = green_sums[col] + g;
        blue_sums[col]  = blue_sums[col] + b;
      end
      if (xin == tw - 1 && yin == th - 1) begin
        area        = tw * th;
        t.row       = TILE_ROW_W'(row);
        t.col       = TILE_COL_W'(col);
        t.avg_red   = PIX_W'(red_sums[col] / area);
        t.avg_green = PIX_W'(green_sums[col] / area);
        t.avg_blue  = PIX_W'(blue_sums[col] / area);
        t.last      = (row == GRID_ROWS - 1) && (col == GRID_COLS - 1);
        pending_tiles.push_back(t);
      end
    end
    rast_x++;
    if (rast_x >= w) begin
      rast_x = 0;
      rast_y++;
      if (rast_y >= h) rast_y = 0;
    end
  endtask

  task automatic check_tile();
    tile_t want;
    if (pending_tiles.size() == 0) begin
      report_mismatch($sformatf("tile row %0d col %0d with none pending",
                                tile_ch.tile_row, tile_ch.tile_col));
    end else begin
      want = pending_tiles.pop_front();
      if (tile_ch.tile_row !== want.row)
        report_mismatch($sformatf("tile_row got %0d want %0d", tile_ch.tile_row, want.row));
      if (tile_ch.tile_col !== want.col)
        report_mismatch($sformatf("tile_col got %0d want %0d", tile_ch.tile_col, want.col));
      if (tile_ch.avg_red !== want.avg_red)
        report_mismatch($sformatf("avg_red got %0d want %0d (tile %0d,%0d)",
                                  tile_ch.avg_red, want.avg_red, want.row, want.col));
      if (tile_ch.avg_green !== want.avg_green)
        report_mismatch($sformatf("avg_green got %0d want %0d (tile %0d,%0d)",
                                  tile_ch.avg_green, want.avg_green, want.row, want.col));
      if (tile_ch.avg_blue !== want.avg_blue)
        report_mismatch($sformatf("avg_blue got %0d want %0d (tile %0d,%0d)",
                                  tile_ch.avg_blue, want.avg_blue, want.row, want.col));
      if (tile_ch.last_tile !== want.last)
        report_mismatch($sformatf("last_tile got %0b want %0b (tile %0d,%0d)",
                                  tile_ch.last_tile, want.last, want.row, want.col));
    end
  endtask

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else if (!pix_ch.valid || pix_ch.ready) begin
      if (pixel_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 14)) begin
        next_beat = pixel_backlog.pop_front();
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_red   <= next_beat.red;
        pix_ch.pixel_green <= next_beat.green;
        pix_ch.pixel_blue  <= next_beat.blue;
        pix_ch.frame_start <= next_beat.start;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // tile receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      tile_ch.ready <= 1'b0;
    end else begin
      tile_ch.ready <= steady || ($urandom_range(0, 99) >= 14);
    end
  end

  // monitor: register writes, accepted pixel beats, accepted tile beats
  always @(posedge clk) begin
    if (rst) begin
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      rast_x     = 0;
      rast_y     = 0;
      for (int i = 0; i < GRID_COLS; i++) begin
        red_sums[i]   = '0;
        green_sums[i] = '0;
        blue_sums[i]  = '0;
      end
    end else begin
      if (cfg_write_en) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:  width_reg = cfg_data;
          CFG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (pix_ch.valid && pix_ch.ready)
        accumulate_pixel(pix_ch.pixel_red, pix_ch.pixel_green, pix_ch.pixel_blue,
                         pix_ch.frame_start);
      if (tile_ch.valid && tile_ch.ready) check_tile();
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= idx;
    cfg_data     <= DIM_W'(val);
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic queue_pixels(input int count, input bit restart, input int restart_pct);
    pix_beat_t b;
    for (int i = 0; i < count; i++) begin
      b.red   = PIX_W'($urandom);
      b.green = PIX_W'($urandom);
      b.blue  = PIX_W'($urandom);
      b.start = (i == 0) ? restart : ($urandom_range(0, 99) < restart_pct);
      pixel_backlog.push_back(b);
    end
  endtask

  // wait until every beat is in and every tile is out, then let the pipe empty
  task automatic drain_all();
    int n;
    n = 0;
    while ((pixel_backlog.size() != 0 || pix_ch.valid || pending_tiles.size() != 0)
           && n < 50000) begin
      @(negedge clk);
      n++;
    end
    if (pending_tiles.size() != 0) begin
      report_mismatch($sformatf("%0d tiles never arrived", pending_tiles.size()));
      pending_tiles.delete();
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic run_setting(input int unsigned w, input int unsigned h, input int count,
                             input int restart_pct);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    queue_pixels(count, 1'b1, restart_pct);
    drain_all();
  endtask

  initial begin
    #8_000_000;
    $display("** tile_average_downscaler_unit: FAILED **");
    $finish;
  end

  initial begin
    int rand_items, seg;
    int unsigned w, h, pick;
    rst                = 1'b1;
    cfg_write_en       = 1'b0;
    cfg_index          = CFG_IMAGE_WIDTH;
    cfg_data           = '0;
    pix_ch.valid       = 1'b0;
    pix_ch.pixel_red   = '0;
    pix_ch.pixel_green = '0;
    pix_ch.pixel_blue  = '0;
    pix_ch.frame_start = 1'b0;
    tile_ch.ready      = 1'b0;
    steady             = 1'b0;
    mismatch_count     = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset geometry 64x32: one-pixel tiles, every covered beat yields a tile
    pixel_backlog.push_back('{8'h00, 8'h00, 8'h00, 1'b1});
    pixel_backlog.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b0});
    pixel_backlog.push_back('{8'hAA, 8'h55, 8'hF0, 1'b0});
    pixel_backlog.push_back('{8'h55, 8'hAA, 8'h0F, 1'b0});
    pixel_backlog.push_back('{8'h01, 8'h02, 8'h03, 1'b1});  // restart mid-frame
    pixel_backlog.push_back('{8'h80, 8'h7F, 8'h01, 1'b0});
    pixel_backlog.push_back('{8'hFE, 8'hFD, 8'hFB, 1'b0});
    pixel_backlog.push_back('{8'h7F, 8'h80, 8'hFE, 1'b1});
    drain_all();

    // fill rows up to line 3 so every column sum holds a written value
    queue_pixels(3 * GRID_COLS - (rast_y * GRID_COLS + rast_x), 1'b0, 0);
    drain_all();

    // grow to 2x2 tiles mid-frame: line 3 lands on the second row of a tile
    write_reg(CFG_IMAGE_WIDTH, 128);
    write_reg(CFG_IMAGE_HEIGHT, 64);
    queue_pixels(228, 1'b0, 0);
    drain_all();

    // shrink back while x sits past the new width: that beat is dropped
    write_reg(CFG_IMAGE_WIDTH, 64);
    write_reg(CFG_IMAGE_HEIGHT, 32);
    queue_pixels(30, 1'b0, 0);
    drain_all();

    // one whole frame with no stalls, through the last tile and the wrap
    steady = 1'b1;
    queue_pixels(GRID_COLS * GRID_ROWS + 20, 1'b1, 0);
    drain_all();
    steady = 1'b0;

    // size extremes, including out-of-range values that clamp
    run_setting(MAX_IMAGE_DIM, GRID_ROWS, 200, 0);
    run_setting(8191, 0, 130, 0);
    run_setting(MAX_IMAGE_DIM - 1, GRID_ROWS, 140, 0);
    run_setting(0, MAX_IMAGE_DIM, 100, 0);
    run_setting(GRID_COLS, 256, 512, 0);

    rand_items = 0;
    while (rand_items < 1800) begin
      seg = $urandom_range(50, 700);
      if ($urandom_range(0, 99) < 20) begin
        // same geometry, raster just carries on
        queue_pixels(seg, 1'b0, 1);
        drain_all();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          w = $urandom_range(64, 127);
          h = $urandom_range(32, 63);
        end else if (pick < 70) begin
          w = $urandom_range(128, 191);
          h = $urandom_range(64, 95);
        end else if (pick < 80) begin
          w = $urandom_range(192, 255);
          h = $urandom_range(32, 127);
        end else if (pick < 90) begin
          w = $urandom_range(0, 63);
          h = $urandom_range(0, 31);
        end else begin
          w = $urandom_range(3000, 8191);
          h = $urandom_range(0, 63);
        end
        run_setting(w, h, seg, 1);
      end
      rand_items += seg;
    end

    drain_all();
    if (mismatch_count == 0) begin
      $display("** tile_average_downscaler_unit: PASSED **");
    end else begin
      $display("** tile_average_downscaler_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tad_pkg.sv
sv/tad_if.sv
sv/tad_ram.sv
sv/tad_divider.sv
sv/tad_mean.sv
sv/tad_fifo.sv
sv/tile_average_downscaler_unit.sv
sv/tad_checker.sv
tb/sv/tb.sv
